// ===== rtl/core/lomb_pkg.sv =====
package lomb_pkg;

  localparam int STAMP_W       = 31;
  localparam int PAYLOAD_W     = 64;
  localparam int CAP_W         = 6;
  localparam int RCNT_W        = 6;
  localparam int DEPTH_DEFAULT = 32;
  localparam int RESULT_LIMIT  = 32;
  localparam int CAP_RESET     = 32;

  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic                 entry_valid;
    logic [STAMP_W-1:0]   stamp;
    logic [PAYLOAD_W-1:0] payload;
    logic                 evicted;
    logic                 last;
  } res_t;

endpackage

// ===== rtl/core/lamport_ordered_message_buffer.sv =====
// Sorted store of up to DEPTH messages, ordered by Lamport stamp, in one memory
// used as a ring. An insert whose store is empty after any eviction writes its
// entry at once; otherwise it holds busy while it walks down from the tail, one
// memory read and one write per cycle as entries with larger stamps move up one
// slot. A read of n entries holds busy while its memory reads are issued; its
// words are produced one per cycle once the read data is registered (an empty
// store gives one word with no entry). Each word is registered onto the result
// ports, marked by result_valid for exactly one cycle; the receiver cannot stall,
// so it must take every word as it comes. Capacity may only be written while
// busy is low.
module lamport_ordered_message_buffer import lomb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command,
  input  logic                 has_stamp,
  input  logic [STAMP_W-1:0]   stamp,
  input  logic [PAYLOAD_W-1:0] payload,
  input  logic [RCNT_W-1:0]    read_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAP_W-1:0]     cfg_data,
  output logic                 result_valid,
  output logic                 kind,
  output logic                 entry_valid,
  output logic [STAMP_W-1:0]   entry_stamp,
  output logic [PAYLOAD_W-1:0] entry_payload,
  output logic                 evicted,
  output logic                 last
);

  logic               accept;
  logic [CAP_W-1:0]   capacity;
  logic [STAMP_W-1:0] stamp_asg;
  res_t               res;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  lomb_clock u_clock (
    .clk       (clk),
    .rst       (rst),
    .update    (accept && (command == CMD_INSERT)),
    .has_stamp (has_stamp),
    .stamp     (stamp),
    .assigned  (stamp_asg)
  );

  lomb_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (command),
    .stamp_asg  (stamp_asg),
    .payload    (payload),
    .read_count (read_count),
    .capacity   (capacity),
    .busy       (busy),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    kind          <= res.kind;
    entry_valid   <= res.entry_valid;
    entry_stamp   <= res.stamp;
    entry_payload <= res.payload;
    evicted       <= res.evicted;
    last          <= res.last;
  end

endmodule

// ===== rtl/core/lomb_clock.sv =====
module lomb_clock import lomb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               update,
  input  logic               has_stamp,
  input  logic [STAMP_W-1:0] stamp,
  output logic [STAMP_W-1:0] assigned
);

  logic [STAMP_W-1:0] lamport_time;
  logic [STAMP_W-1:0] high;

  assign assigned = has_stamp ? stamp : lamport_time;
  assign high     = (lamport_time > assigned) ? lamport_time : assigned;

  always_ff @(posedge clk) begin
    if (rst) begin
      lamport_time <= '0;
    end else if (update) begin
      lamport_time <= (high == STAMP_MAX) ? high : high + STAMP_W'(1);
    end
  end

endmodule

// ===== rtl/core/lomb_core.sv =====
module lomb_core import lomb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 command,
  input  logic [STAMP_W-1:0]   stamp_asg,
  input  logic [PAYLOAD_W-1:0] payload,
  input  logic [RCNT_W-1:0]    read_count,
  input  logic [CAP_W-1:0]     capacity,
  output logic                 busy,
  output res_t                 res
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int WW   = STAMP_W + PAYLOAD_W;
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int NW   = (CW > RCNT_W) ? CW : RCNT_W;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_INS_RD  = 2'd1;
  localparam logic [1:0] S_INS_CHK = 2'd2;
  localparam logic [1:0] S_READ    = 2'd3;

  logic [1:0]           state;
  logic [AW-1:0]        head;
  logic [CW-1:0]        count;
  logic [CW-1:0]        pos;
  logic [CW-1:0]        idx;
  logic [STAMP_W-1:0]   asg;
  logic [PAYLOAD_W-1:0] pl;
  logic                 evict;
  logic                 rd_pend;
  logic                 rd_last;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WW-1:0] wr_data;

  logic [CMPW-1:0]    cap_x;
  logic [CW-1:0]      cap_eff;
  logic               full;
  logic [CW-1:0]      drop;
  logic [CW-1:0]      count_ev;
  logic [AW-1:0]      head_ev;
  logic [RCNT_W-1:0]  n0;
  logic [NW-1:0]      nsel;
  logic [STAMP_W-1:0] rd_stamp;
  logic               larger;
  logic               fin;
  logic               rd_done;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(l);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // eviction and read window, both from the state at accept
  always_comb begin
    cap_x = CMPW'(capacity);
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (cap_x > CMPW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_x);
    end
    full     = count >= cap_eff;
    drop     = count - cap_eff + CW'(1);
    count_ev = full ? cap_eff - CW'(1) : count;
    head_ev  = full ? phys(head, drop) : head;

    n0   = (read_count == '0) ? RCNT_W'(1) : read_count;
    nsel = NW'(n0);
    if (nsel > NW'(count)) begin
      nsel = NW'(count);
    end
    if (nsel > NW'(RESULT_LIMIT)) begin
      nsel = NW'(RESULT_LIMIT);
    end
  end

  assign rd_stamp = rd_data[WW-1:PAYLOAD_W];
  assign larger   = rd_stamp > asg;
  assign fin      = ((state == S_INS_RD) && (pos == '0)) || ((state == S_INS_CHK) && !larger);
  assign rd_done  = (state == S_READ) && ((count == '0) || (idx == count - CW'(1)));
  assign busy     = state != S_IDLE;

  // walk down from the tail, shifting larger stamps up one slot
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = phys(head, idx);
    wr_en   = 1'b0;
    wr_addr = phys(head, pos);
    wr_data = {asg, pl};
    unique case (state)
      S_INS_RD: begin
        if (pos == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = phys(head, pos - CW'(1));
        end
      end
      S_INS_CHK: begin
        wr_en = 1'b1;
        if (larger) begin
          wr_data = rd_data;
          if (pos != CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = phys(head, pos - CW'(2));
          end
        end
      end
      S_READ: begin
        rd_en = count != '0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ) && (count != '0);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_INSERT) begin
              head  <= head_ev;
              count <= count_ev;
              state <= S_INS_RD;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            count <= count + CW'(1);
            state <= S_IDLE;
          end else begin
            state <= S_INS_CHK;
          end
        end
        S_INS_CHK: begin
          if (!larger) begin
            count <= count + CW'(1);
            state <= S_IDLE;
          end else if (pos == CW'(1)) begin
            state <= S_INS_RD;
          end
        end
        S_READ: begin
          if (rd_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_last <= idx == count - CW'(1);
    if (state == S_IDLE && accept) begin
      pos   <= count_ev;
      asg   <= stamp_asg;
      pl    <= payload;
      evict <= full;
      idx   <= count - CW'(nsel);
    end else if (state == S_INS_CHK && larger) begin
      pos <= pos - CW'(1);
    end else if (state == S_READ) begin
      idx <= idx + CW'(1);
    end
  end

  always_comb begin
    res = '0;
    if (fin) begin
      res.valid       = 1'b1;
      res.kind        = KIND_ACK;
      res.entry_valid = 1'b1;
      res.stamp       = asg;
      res.payload     = pl;
      res.evicted     = evict;
      res.last        = 1'b1;
    end else if (state == S_READ && count == '0) begin
      res.valid = 1'b1;
      res.kind  = KIND_ENTRY;
      res.last  = 1'b1;
    end else if (rd_pend) begin
      res.valid       = 1'b1;
      res.kind        = KIND_ENTRY;
      res.entry_valid = 1'b1;
      res.stamp       = rd_stamp;
      res.payload     = rd_data[PAYLOAD_W-1:0];
      res.last        = rd_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_same_addr: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("read and write hit the same entry");

  a_chk_has_data: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_CHK |-> $past(rd_en))
    else $error("compare without a read issued");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !wr_en)
    else $error("memory write while idle");

  a_one_result_source: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !fin)
    else $error("read word and insert word collide");
`endif

endmodule
